// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// lbl: prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// lbl: cons must hold in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ded_pkg.sv -----
// ----------------------------------------------------------------------------
// ded_pkg
// Shared constants, types and helpers of the decimal escape decoder.
// ----------------------------------------------------------------------------
package ded_pkg;

    localparam logic [7:0] PCT        = 8'h25;   // '%'
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // results one payload beat can raise
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // register map: index bit of paddr (byte address 4*i)
    localparam int  PADDR_W          = 3;
    localparam logic REG_WATCHED_PORT = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]        count;   // results in this beat, 0..4
        logic [MAX_RES-1:0][7:0] data;    // slot 0 goes out first
        logic [MAX_RES-1:0]      last;
    } ded_push_t;

    typedef struct packed {
        logic       pending;
        logic       selected;
        logic [1:0] la_count;
    } ded_status_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] b);
        logic [7:0] diff;
        diff = b - DIGIT_ZERO;
        return is_digit(b) ? diff[3:0] : 4'd0;
    endfunction

endpackage

// ----- hw/rtl/ded_if.sv -----
// ----------------------------------------------------------------------------
// ded_if
// Valid/ready channels of the decoder: payload beats in, result beats out.
// ----------------------------------------------------------------------------
interface ded_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        is_tcp_ipv4;
    logic [15:0] pkt_port;

    modport source (output valid, data_byte, last_byte, is_tcp_ipv4, pkt_port,
                    input ready);
    modport sink   (input valid, data_byte, last_byte, is_tcp_ipv4, pkt_port,
                    output ready);
endinterface

interface ded_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ----- hw/rtl/ded_escape_core.sv -----
// ----------------------------------------------------------------------------
// ded_escape_core
// Packet selection and escape resolution; one payload beat per cycle
// while accept is high, up to four result bytes raised per beat.
// ----------------------------------------------------------------------------
module ded_escape_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                is_tcp_ipv4,
    input  logic [15:0]         pkt_port,
    input  logic [15:0]         watched_port,
    output ded_pkg::ded_push_t   push,
    output ded_pkg::ded_status_t status
);

    logic       at_start_reg, at_start_next;
    logic       selected_reg, selected_next;
    logic       pending_reg,  pending_next;
    logic [1:0] la_count_reg, la_count_next;
    logic [7:0] la_bytes_reg  [2];
    logic [7:0] la_bytes_next [2];

    logic       sel;
    logic [1:0] held_c;             // held bytes incl. the new one
    logic       resolve_now;
    logic [7:0] lb [4];
    logic [3:0] v0, v1, v2;
    logic       d0, d1, d2;
    logic [6:0] val2;
    logic [9:0] val3;
    logic [1:0] used;
    logic [7:0] first_byte;
    logic       drop;
    logic [1:0] left;
    logic [2:0] pos;
    logic [ded_pkg::CNT_W-1:0] n;
    logic [ded_pkg::MAX_RES-1:0][7:0] slot;

    always_comb
    begin
        sel    = at_start_reg ? (is_tcp_ipv4 && (pkt_port == watched_port)) : selected_reg;
        held_c = la_count_reg + 2'd1;

        lb[0] = (la_count_reg == 2'd0) ? data_byte : la_bytes_reg[0];
        lb[1] = (la_count_reg == 2'd1) ? data_byte : la_bytes_reg[1];
        lb[2] = data_byte;
        lb[3] = '0;

        d0 = ded_pkg::is_digit(lb[0]);
        d1 = ded_pkg::is_digit(lb[1]);
        d2 = ded_pkg::is_digit(lb[2]);
        v0 = ded_pkg::digit_val(lb[0]);
        v1 = ded_pkg::digit_val(lb[1]);
        v2 = ded_pkg::digit_val(lb[2]);
        val2 = 7'(v0) * 7'd10 + 7'(v1);
        val3 = 10'(val2) * 10'd10 + 10'(v2);

        resolve_now = (held_c == 2'd3) || last_byte || !ded_pkg::is_digit(data_byte);

        // longest decodable run first
        priority if (held_c == 2'd3 && d0 && d1 && d2 && val3 >= 10'd1 && val3 <= 10'd255)
        begin
            used = 2'd3; first_byte = val3[7:0];
        end
        else if (held_c >= 2'd2 && d0 && d1 && val2 != 7'd0)
        begin
            used = 2'd2; first_byte = {1'b0, val2};
        end
        else if (d0 && v0 != 4'd0)
        begin
            used = 2'd1; first_byte = {4'd0, v0};
        end
        else
        begin
            used = 2'd0; first_byte = ded_pkg::PCT;
        end

        // a trailing '%' opens a fresh escape instead of going out
        drop = (data_byte == ded_pkg::PCT) && !last_byte;
        left = held_c - used - {1'b0, drop};

        slot[0] = first_byte;
        for (int i = 0; i < ded_pkg::MAX_RES - 1; i++)
        begin
            pos         = 3'(used) + 3'(i);
            slot[i + 1] = lb[pos[1:0]];
        end

        at_start_next    = at_start_reg;
        selected_next    = selected_reg;
        pending_next     = pending_reg;
        la_count_next    = la_count_reg;
        la_bytes_next[0] = la_bytes_reg[0];
        la_bytes_next[1] = la_bytes_reg[1];
        n                = '0;
        push.data        = '0;

        if (accept)
        begin
            at_start_next = last_byte;
            selected_next = sel;
            if (!sel)
            begin
                n = 3'd1; push.data[0] = data_byte;
            end
            else if (!pending_reg)
            begin
                if (data_byte == ded_pkg::PCT && !last_byte)
                begin
                    pending_next  = 1'b1;
                    la_count_next = 2'd0;
                end
                else
                begin
                    n = 3'd1; push.data[0] = data_byte;
                end
            end
            else if (resolve_now)
            begin
                n             = 3'd1 + 3'(left);
                push.data     = slot;
                pending_next  = drop;
                la_count_next = 2'd0;
            end
            else
            begin
                la_bytes_next[la_count_reg[0]] = data_byte;
                la_count_next                  = held_c;
            end

            if (last_byte)
            begin
                pending_next  = 1'b0;
                la_count_next = 2'd0;
            end
        end

        push.count = n;
        for (int i = 0; i < ded_pkg::MAX_RES; i++)
            push.last[i] = accept && last_byte && (3'(i) == n - 3'd1);

        status.pending  = pending_reg;
        status.selected = selected_reg;
        status.la_count = la_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            selected_reg <= 1'b0;
            pending_reg  <= 1'b0;
            la_count_reg <= 2'd0;
        end
        else
        begin
            at_start_reg <= at_start_next;
            selected_reg <= selected_next;
            pending_reg  <= pending_next;
            la_count_reg <= la_count_next;
        end
    end

    // held bytes: payload only
    always_ff @(posedge clk)
    begin
        la_bytes_reg[0] <= la_bytes_next[0];
        la_bytes_reg[1] <= la_bytes_next[1];
    end

endmodule

// ----- hw/rtl/ded_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ded_out_fifo
// Result queue: takes up to four bytes a cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module ded_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  ded_pkg::ded_push_t push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    logic [7:0]                  byte_mem [ded_pkg::FIFO_DEPTH];
    logic                        last_mem [ded_pkg::FIFO_DEPTH];
    logic [ded_pkg::FIFO_AW-1:0] head_reg, head_next;
    logic [ded_pkg::FIFO_AW-1:0] tail_reg, tail_next;
    logic [ded_pkg::FIFO_AW:0]   count_reg, count_next;
    logic                        pop;

    always_comb
    begin
        pop        = out_valid && out_ready;
        head_next  = head_reg + ded_pkg::FIFO_AW'(pop);
        tail_next  = tail_reg + ded_pkg::FIFO_AW'(push.count);
        count_next = count_reg + (ded_pkg::FIFO_AW + 1)'(push.count)
                     - (ded_pkg::FIFO_AW + 1)'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign out_byte  = byte_mem[head_reg];
    assign out_last  = last_mem[head_reg];
    assign space_ok  = (count_reg <= (ded_pkg::FIFO_AW + 1)'(ded_pkg::FIFO_DEPTH
                                                          - ded_pkg::MAX_RES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ded_pkg::MAX_RES; i++)
        begin
            if (ded_pkg::CNT_W'(i) < push.count)
            begin
                byte_mem[tail_reg + ded_pkg::FIFO_AW'(i)] <= push.data[i];
                last_mem[tail_reg + ded_pkg::FIFO_AW'(i)] <= push.last[i];
            end
        end
    end

endmodule

// ----- hw/rtl/decimal_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// decimal_escape_decoder
// Replaces '%' + decimal digits with one byte in the payloads of TCP
// packets aimed at the watched port; other packets pass unchanged.
// ----------------------------------------------------------------------------
// Use:
//   payload : sink channel, one TCP payload byte per beat, last_byte on
//             the final byte of each packet; is_tcp_ipv4 and pkt_port are
//             sampled on the first beat of a packet only.
//   result  : source channel, one output byte per beat, out_last on the
//             final byte of each packet.
//   APB     : watched_port at byte address 0; pready is tied high. Write
//             it only while the block is idle; it applies from the next
//             packet.
// Output: results of a beat are written to the output queue at the edge
//   that takes the beat and leave it one per cycle while result.ready is high.
// Throughput: one payload beat per cycle. A beat raises 0 to 4 results,
//   never more in total than beats taken, so the 8-entry queue keeps up.
//   payload.ready drops while the queue holds more than four bytes.
// Stall: a stalled receiver fills the queue, then payload.ready falls;
//   nothing is lost. Reset empties the queue, drops any held escape,
//   clears watched_port and waits for the start of a packet.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_escape_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    ded_in_if.sink                      payload,
    ded_out_if.source                   result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ded_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0]          watched_port_reg;
    logic                 cfg_write;
    logic                 accept;
    logic                 space_ok;
    ded_pkg::ded_push_t   push;
    ded_pkg::ded_status_t core_status;

    // ---- configuration ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == ded_pkg::REG_WATCHED_PORT);
    assign prdata    = (paddr[2] == ded_pkg::REG_WATCHED_PORT)
                       ? {16'd0, watched_port_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            watched_port_reg <= 16'd0;
        else if (cfg_write)
            watched_port_reg <= pwdata[15:0];
    end

    // ---- payload side: accept whenever the queue has room for a full beat ----
    assign payload.ready = space_ok;
    assign accept        = payload.valid && space_ok;

    ded_escape_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (payload.data_byte),
        .last_byte    (payload.last_byte),
        .is_tcp_ipv4  (payload.is_tcp_ipv4),
        .pkt_port     (payload.pkt_port),
        .watched_port (watched_port_reg),
        .push         (push),
        .status       (core_status)
    );

    // ---- result side ----
    ded_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_byte  (result.out_byte),
        .out_last  (result.out_last)
    );

    // ---- checks ----
    `ASSERT_IMPL(a_pending_in_selected, clk, rst_n, core_status.pending, core_status.selected, "escape held in a packet that is not decoded")
    `ASSERT_IMPL(a_held_needs_escape, clk, rst_n, core_status.la_count != 2'd0, core_status.pending, "bytes held without an open escape")
    `ASSERT_IMPL(a_last_gives_result, clk, rst_n, accept && payload.last_byte, push.count != 3'd0, "packet end raised no result beat")
    `ASSERT_ALWAYS(a_push_bound, clk, rst_n, push.count <= 3'(ded_pkg::MAX_RES), "more than four results from one beat")

endmodule

// ----- tb/tb_decimal_escape_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_escape_decoder
// Self-checking bench for the decimal escape decoder. A scoreboard class
// carries its own decoder state, predicts the output bytes of every payload
// beat taken, and matches each result beat against the oldest prediction.
// A short directed run is followed by random packets over four idling mixes
// and several watched ports.
// ----------------------------------------------------------------------------
module tb_decimal_escape_decoder;

    // settle time after the last due result beat; a packet's final beat
    // resolves any held escape, so none is still open then
    localparam int DRAIN_SETTLE = 6;
    localparam int SHOW_LIMIT   = 10;

    localparam logic [ded_pkg::PADDR_W-1:0] ADDR_WATCHED_PORT =
        {ded_pkg::REG_WATCHED_PORT, 2'b00};

    typedef logic [7:0] byte_q_t [$];

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: decoder state of its own plus the queue of bytes still due.
    // ------------------------------------------------------------------------
    class escape_decode_scoreboard;
        logic [15:0] port_cfg;
        bit [7:0]    held [3];    // bytes held after a '%'
        int          held_cnt;
        bit          esc_held;
        bit          selected;
        bit          at_start;
        out_beat_t   due_bytes [$];
        int          mismatches;
        int          checked;

        function new();
            port_cfg   = '0;
            held_cnt   = 0;
            esc_held   = 1'b0;
            selected   = 1'b0;
            at_start   = 1'b1;
            mismatches = 0;
            checked    = 0;
        endfunction

        function bit is_dec(logic [7:0] b);
            return (b >= ded_pkg::DIGIT_ZERO) && (b <= ded_pkg::DIGIT_NINE);
        endfunction

        function void push_out(logic [7:0] b);
            out_beat_t o;
            o.data = b;
            o.last = 1'b0;
            due_bytes.push_back(o);
        endfunction

        // Judge the held bytes: three digits 1..255, else two digits nonzero,
        // else one nonzero digit, else the '%' itself. Leftovers go out as
        // plain bytes; a '%' among them opens a new escape unless at the end.
        function void resolve_escape(bit last);
            int unsigned dv [3];
            bit          dg [3];
            int unsigned two;
            int unsigned three;
            int          used;
            int          n;
            n = held_cnt;
            for (int i = 0; i < 3; i++)
            begin
                dg[i] = (i < n) && is_dec(held[i]);
                dv[i] = dg[i] ? int'(held[i] - ded_pkg::DIGIT_ZERO) : 0;
            end
            two   = dv[0] * 10 + dv[1];
            three = two * 10 + dv[2];
            if (n == 3 && dg[0] && dg[1] && dg[2] && three >= 1 && three <= 255)
            begin
                push_out(three[7:0]);
                used = 3;
            end
            else if (n >= 2 && dg[0] && dg[1] && two != 0)
            begin
                push_out(two[7:0]);
                used = 2;
            end
            else if (n >= 1 && dg[0] && dv[0] != 0)
            begin
                push_out(dv[0][7:0]);
                used = 1;
            end
            else
            begin
                push_out(ded_pkg::PCT);
                used = 0;
            end
            esc_held = 1'b0;
            held_cnt = 0;
            for (int i = used; i < n; i++)
            begin
                if (held[i] == ded_pkg::PCT && !last)
                begin
                    esc_held = 1'b1;
                    break;
                end
                push_out(held[i]);
            end
        endfunction

        // One payload beat taken by the block: append the bytes it yields.
        function void predict_beat(logic [7:0] b, logic last, logic tcp, logic [15:0] port);
            int queued;
            queued = due_bytes.size();
            if (at_start)
                selected = tcp && (port == port_cfg);
            at_start = last;
            if (!selected)
                push_out(b);
            else if (!esc_held)
            begin
                if (b == ded_pkg::PCT && !last)
                begin
                    esc_held = 1'b1;
                    held_cnt = 0;
                end
                else
                    push_out(b);
            end
            else
            begin
                if (held_cnt < 3)
                begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
                if (held_cnt >= 3 || last || !is_dec(b))
                    resolve_escape(last);
            end
            if (last)
            begin
                if (due_bytes.size() > queued)
                    due_bytes[due_bytes.size() - 1].last = 1'b1;
                esc_held = 1'b0;
                held_cnt = 0;
            end
        endfunction

        function void flag(string what, logic [7:0] eb, logic el, logic [7:0] gb, logic gl);
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                         $time, what, eb, el, gb, gl);
        endfunction

        function void check_output(logic [7:0] b, logic l);
            out_beat_t want;
            checked++;
            if (due_bytes.size() == 0)
            begin
                flag("result beat with nothing due", 8'hxx, 1'bx, b, l);
                return;
            end
            want = due_bytes.pop_front();
            if (want.data !== b)
                flag("out_byte mismatch", want.data, want.last, b, l);
            else if (want.last !== l)
                flag("out_last mismatch", want.data, want.last, b, l);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ded_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ded_in_if  pay_if ();
    ded_out_if res_if ();

    decimal_escape_decoder DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (pay_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    escape_decode_scoreboard escape_check = new();

    int src_idle_pct;     // chance in 100 that the sender holds back a cycle
    int sink_stall_pct;   // chance in 100 that the receiver stalls a cycle
    int beats_sent;
    int packets_sent;

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // generous ceiling; a correct run needs a small fraction of it
    initial
    begin
        #400000;
        $display("Timeout: %0d result beats still due", escape_check.due_bytes.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: sample at the rising edge, choose ready at the falling one
    // ------------------------------------------------------------------------
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                escape_check.check_output(res_if.out_byte, res_if.out_last);
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered and left just after a falling edge.
    // ------------------------------------------------------------------------

    // APB write: setup cycle, then access cycle until pready
    task automatic write_port(input logic [15:0] port);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WATCHED_PORT;
        pwdata  <= {16'h0000, port};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        escape_check.port_cfg = port;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One payload beat, with random idle cycles ahead of it. valid is left
    // high on return so back-to-back beats never toggle it within a step.
    task automatic send_beat(input logic [7:0] b, input logic last, input logic tcp,
                             input logic [15:0] port);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pay_if.valid <= 1'b0;
            @(negedge clk);
        end
        pay_if.valid       <= 1'b1;
        pay_if.data_byte   <= b;
        pay_if.last_byte   <= last;
        pay_if.is_tcp_ipv4 <= tcp;
        pay_if.pkt_port    <= port;
        do
            @(posedge clk);
        while (!pay_if.ready);
        escape_check.predict_beat(b, last, tcp, port);
        beats_sent++;
        @(negedge clk);
    endtask

    // Whole packet; with wobble set, header fields change after the first
    // beat, which the block must ignore until the next packet.
    task automatic send_packet(input byte_q_t body, input logic tcp, input logic [15:0] port,
                               input bit wobble);
        logic        t;
        logic [15:0] p;
        for (int i = 0; i < body.size(); i++)
        begin
            t = tcp;
            p = port;
            if (wobble && i > 0)
            begin
                t = 1'($urandom_range(1));
                p = 16'($urandom_range(65535));
            end
            send_beat(body[i], i == body.size() - 1, t, p);
        end
        packets_sent++;
    endtask

    // Sender holds off until every due byte is out, then waits out the settle time
    task automatic wait_idle();
        pay_if.valid <= 1'b0;
        while (escape_check.due_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic byte_q_t text_bytes(string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Escapes with zero to four random digits, mixed with bare '%', single '0'
    // bytes and arbitrary bytes; cut to the wanted length.
    function automatic byte_q_t random_payload(int len);
        byte_q_t q;
        int      digits;
        while (q.size() < len)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    q.push_back(ded_pkg::PCT);
                    digits = $urandom_range(4);
                    for (int k = 0; k < digits; k++)
                    begin
                        // lead digit often 0..2 so three-digit values land near 255
                        if (k == 0 && $urandom_range(1))
                            q.push_back(ded_pkg::DIGIT_ZERO + 8'($urandom_range(2)));
                        else
                            q.push_back(ded_pkg::DIGIT_ZERO + 8'($urandom_range(9)));
                    end
                end
                4:
                    q.push_back(ded_pkg::PCT);
                5:
                    q.push_back(ded_pkg::DIGIT_ZERO);
                default:
                    q.push_back(8'($urandom_range(255)));
            endcase
        end
        while (q.size() > len)
            void'(q.pop_back());
        return q;
    endfunction

    // Directed cases; the watched port is still at its reset value of zero
    task automatic run_directed();
        byte_q_t raw;
        send_packet(text_bytes("%255"), 1'b1, 16'h0000, 1'b0);   // top of the range
        send_packet(text_bytes("%256A"), 1'b1, 16'h0000, 1'b0);  // over range: two digits
        send_packet(text_bytes("%000"), 1'b1, 16'h0000, 1'b0);   // all zero: '%' kept
        send_packet(text_bytes("%5%12"), 1'b1, 16'h0000, 1'b0);  // held '%' opens new escape
        send_packet(text_bytes("%0%"), 1'b1, 16'h0000, 1'b0);    // '%' held at packet end
        raw = {8'h00, ded_pkg::PCT, 8'hFF};
        send_packet(raw, 1'b0, 16'h0000, 1'b0);                  // not TCP: pass through
        send_packet(text_bytes("%1"), 1'b1, 16'hFFFF, 1'b0);     // other port: pass through
        send_packet(text_bytes("%"), 1'b1, 16'h0000, 1'b0);      // lone '%' as final byte
    endtask

    // Random packets under one idling mix and one watched port. Most packets
    // hit the watched port over TCP so the escape logic is exercised.
    task automatic run_phase(input int beats, input int idle_pct, input int stall_pct,
                             input logic [15:0] port, input bit pause_midway);
        int          first_beat;
        int          len;
        int          pick;
        bit          paused;
        logic        tcp;
        logic [15:0] dport;
        write_port(port);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        first_beat     = beats_sent;
        paused         = 1'b0;
        while (beats_sent - first_beat < beats)
        begin
            if (pause_midway && !paused && beats_sent - first_beat >= beats / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            len   = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            pick  = $urandom_range(9);
            tcp   = (pick != 7);
            dport = (pick >= 8) ? 16'($urandom_range(65535)) : port;
            send_packet(random_payload(len), tcp, dport, $urandom_range(9) == 0);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pay_if.valid       = 1'b0;
        pay_if.data_byte   = '0;
        pay_if.last_byte   = 1'b0;
        pay_if.is_tcp_ipv4 = 1'b0;
        pay_if.pkt_port    = '0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        beats_sent         = 0;
        packets_sent       = 0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_idle();

        // idling mixes: none, sender idle, receiver stalls, both at once
        run_phase(100, 0, 0, 16'hFFFF, 1'b0);
        run_phase(100, 60, 0, 16'($urandom_range(65535)), 1'b1);
        run_phase(100, 0, 60, 16'h0000, 1'b0);
        run_phase(100, 27, 27, 16'($urandom_range(65535)), 1'b0);

        $display("Covered %0d payload beats in %0d packets, %0d result beats checked,",
                 beats_sent, packets_sent, escape_check.checked);
        $display("over four idling mixes and watched ports 0, FFFF and two random; %0d mismatches",
                 escape_check.mismatches);
        if (escape_check.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
